>>> design/u16ss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16ss_pkg: shared types and constants for the UTF-16 substring search
// Function codes, word layouts and pattern capacity.
// ----------------------------------------------------------------------------
package u16ss_pkg;

  // Pattern capacity in code units (1 to 256)
  localparam int PATTERN_MAX = 32;
  // Width of the pattern unit count (holds 0 .. PATTERN_MAX)
  localparam int CNT_W = $clog2(PATTERN_MAX + 1);
  // Width of an index into the pattern store
  localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  // Input word function codes
  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_TEXT   = 2'd2,
    FUNC_END    = 2'd3
  } func_t;

  // Input word
  typedef struct packed {
    func_t       func;
    logic [15:0] code_unit;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic found;
    logic status;
  } out_word_t;

endpackage

>>> design/utf16_substring_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf16_substring_search: exact substring search over 16-bit code units
// Loads a pattern unit by unit, streams text units through a bit-parallel
// prefix match vector and reports a sticky found flag and an overflow status at end of text.
// ----------------------------------------------------------------------------
// Result path: an end-of-text word passes the input register, then the result
//   register; it waits in the input register while the result register is full.
// Throughput: 1 word per cycle outside that wait; the whole match vector updates
//   in one step from one row of 16-bit comparators, one per pattern unit.
// Reset: synchronous rst_n clears the pattern count, match vector, flags and
//   valid bits; pattern unit storage is not reset.
module utf16_substring_search (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  u16ss_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output u16ss_pkg::out_word_t out_data
);

  localparam int PMAX  = u16ss_pkg::PATTERN_MAX;
  localparam int CNT_W = u16ss_pkg::CNT_W;
  localparam int IDX_W = u16ss_pkg::IDX_W;

  // Input register
  logic                 s1_valid_r;
  u16ss_pkg::in_word_t  s1_data_r;

  // Search state
  logic [15:0]          units_r [PMAX];
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [PMAX-1:0]      vec_r, vec_nxt;
  logic                 found_r, found_nxt;
  logic                 ovf_r, ovf_nxt;

  // Result register
  logic                 out_valid_r;
  u16ss_pkg::out_word_t out_data_r;

  logic                 s1_fire;
  logic                 s1_is_end;
  logic                 out_free;
  logic                 in_fire;
  logic                 room;
  logic [PMAX-1:0]      lane_act;
  logic [PMAX-1:0]      lane_eq;
  logic [PMAX-1:0]      lane_last;
  logic [PMAX-1:0]      text_vec;
  logic                 text_hit;
  u16ss_pkg::out_word_t res;

  // Handshake: stage 1 drains unless it holds an end word and the result
  // register is still occupied
  assign out_free  = !out_valid_r || out_ready;
  assign s1_is_end = (s1_data_r.func == u16ss_pkg::FUNC_END);
  assign s1_fire   = s1_valid_r && (!s1_is_end || out_free);
  assign in_ready  = !s1_valid_r || s1_fire;
  assign in_fire   = in_valid && in_ready;

  assign room = (cnt_r < CNT_W'(PMAX));

  // Per-lane compare: prefix k+1 ends here if prefix k ended one unit ago
  for (genvar k = 0; k < PMAX; k++) begin : g_lane
    assign lane_act[k]  = (CNT_W'(k) < cnt_r);
    assign lane_last[k] = (CNT_W'(k + 1) == cnt_r);
    assign lane_eq[k]   = (units_r[k] == s1_data_r.code_unit);
    if (k == 0) begin : g_first
      assign text_vec[k] = lane_act[k] && lane_eq[k];
    end else begin : g_next
      assign text_vec[k] = lane_act[k] && lane_eq[k] && vec_r[k-1];
    end
  end

  assign text_hit = |(text_vec & lane_last);

  // Next state for the word in stage 1
  always_comb begin
    cnt_nxt   = cnt_r;
    vec_nxt   = vec_r;
    found_nxt = found_r;
    ovf_nxt   = ovf_r;
    res.found  = (cnt_r == '0) || found_r;
    res.status = ovf_r;
    unique case (s1_data_r.func)
      u16ss_pkg::FUNC_CLEAR: begin
        cnt_nxt   = '0;
        ovf_nxt   = 1'b0;
        vec_nxt   = '0;
        found_nxt = 1'b0;
      end
      u16ss_pkg::FUNC_APPEND: begin
        if (room) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
        vec_nxt   = '0;
        found_nxt = 1'b0;
      end
      u16ss_pkg::FUNC_TEXT: begin
        vec_nxt   = text_vec;
        found_nxt = found_r || text_hit;
      end
      u16ss_pkg::FUNC_END: begin
        vec_nxt   = '0;
        found_nxt = 1'b0;
      end
      default: begin
        vec_nxt = vec_r;
      end
    endcase
  end

  // Pattern store: written at the current count on append
  always_ff @(posedge clk) begin
    if (s1_fire && (s1_data_r.func == u16ss_pkg::FUNC_APPEND) && room) begin
      units_r[cnt_r[IDX_W-1:0]] <= s1_data_r.code_unit;
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      cnt_r       <= '0;
      vec_r       <= '0;
      found_r     <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        cnt_r   <= cnt_nxt;
        vec_r   <= vec_nxt;
        found_r <= found_nxt;
        ovf_r   <= ovf_nxt;
      end
      if (s1_fire && s1_is_end) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_data;
    end
    if (s1_fire && s1_is_end) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(PMAX))
    else $error("pattern count exceeds capacity");

  a_vec_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (vec_r & ~lane_act) == '0)
    else $error("match vector bit set beyond pattern length");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && (s1_data_r.func == u16ss_pkg::FUNC_CLEAR)
    |=> (cnt_r == '0) && (vec_r == '0) && !found_r && !ovf_r)
    else $error("clear did not empty the search state");

  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_is_end |=> out_valid && (vec_r == '0) && !found_r)
    else $error("end of text did not post a result and restart");

  a_empty_found: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_is_end && (cnt_r == '0) |=> out_data.found)
    else $error("empty pattern not reported as found");

endmodule
